[hdl/fha_pkg.sv]
// shared types, codes and constants of the fit heap allocator
package fha_pkg;

   localparam int MAX_BLOCKS_DEF = 32;
   localparam int ADDR_BITS_DEF  = 16;
   localparam int FIELD_W        = 16;
   localparam int STATUS_W       = 3;
   localparam int HDR_W          = 8;
   localparam int CSR_IDX_W      = 2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NULL    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOHEAP  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_FIT_MODE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_LIMIT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_BYTES = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_MERGE_A,
      S_MERGE_B,
      S_MERGE_WR,
      S_DELETE,
      S_REPLY
   } state_type;

   // per-cycle command broadcast to the row of table cells
   typedef struct packed {
      logic shift_all;
      logic del;
      logic wr;
      logic wr_base_en;
      logic wr_size_en;
      logic wr_free_en;
      logic wr_free;
   } cell_ctrl_type;

endpackage

[hdl/fha_req_if.sv]
// request channel of the fit heap allocator
interface fha_req_if import fha_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               operation;
   logic [FIELD_W-1:0] request_size;
   logic [FIELD_W-1:0] release_address;

   modport source (output valid, operation, request_size, release_address, input ready);
   modport sink   (input valid, operation, request_size, release_address, output ready);
endinterface

[hdl/fha_rsp_if.sv]
// response channel of the fit heap allocator
interface fha_rsp_if import fha_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FIELD_W-1:0]  data_address;
   logic [STATUS_W-1:0] status;

   modport source (output valid, data_address, status, input ready);
   modport sink   (input valid, data_address, status, output ready);
endinterface

[hdl/fha_cell.sv]
// one table cell holding a block entry, fed by its upper neighbour
module fha_cell import fha_pkg::*; #(
   parameter int ADDR_BITS = ADDR_BITS_DEF,
   parameter int IW        = 5,
   parameter int IDX       = 0
) (
   input  logic                 clock,
   input  cell_ctrl_type        ctrl,
   input  logic [IW-1:0]        pos,
   input  logic [ADDR_BITS-1:0] wr_base,
   input  logic [ADDR_BITS-1:0] wr_size,
   input  logic [ADDR_BITS-1:0] nbr_base,
   input  logic [ADDR_BITS-1:0] nbr_size,
   input  logic                 nbr_free,
   output logic [ADDR_BITS-1:0] base,
   output logic [ADDR_BITS-1:0] size,
   output logic                 free
);
   localparam logic [IW-1:0] MY_IDX = IW'(IDX);

   logic [ADDR_BITS-1:0] base_ff, base_in;
   logic [ADDR_BITS-1:0] size_ff, size_in;
   logic                 free_ff, free_in;
   logic                 take_nbr, wr_here;

   assign take_nbr = ctrl.shift_all || (ctrl.del && (MY_IDX >= pos));
   assign wr_here  = ctrl.wr && (MY_IDX == pos);

   always_comb begin
      base_in = base_ff;
      size_in = size_ff;
      free_in = free_ff;
      if (take_nbr) begin
         base_in = nbr_base;
         size_in = nbr_size;
         free_in = nbr_free;
      end else if (wr_here) begin
         if (ctrl.wr_base_en) base_in = wr_base;
         if (ctrl.wr_size_en) size_in = wr_size;
         if (ctrl.wr_free_en) free_in = ctrl.wr_free;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      size_ff <= size_in;
      free_ff <= free_in;
   end

   assign base = base_ff;
   assign size = size_ff;
   assign free = free_ff;
endmodule

[hdl/fit_heap_allocator_unit.sv]
// top level of the fit heap allocator: controller and ring of table cells
// an allocate or a rejected free passes scan, decide and reply; a free that lands adds merge a,
// merge b and merge write, and one delete step per neighbour merged; one item at a time
// each item takes one full rotation of the cell ring past the head cell in the scan
// a result waits in the output register while the next item is taken
// reset (synchronous, active high) empties the table, clears the break, restores csrs
module fit_heap_allocator_unit import fha_pkg::*; #(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
   parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [FIELD_W-1:0]   csr_wdata,
   fha_req_if.sink              req_port,
   fha_rsp_if.source            rsp_port
);
   localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int EW = ((ADDR_BITS > FIELD_W) ? ADDR_BITS : FIELD_W) + 2;
   localparam logic [EW-1:0] MASK_E = {{(EW-ADDR_BITS){1'b0}}, {ADDR_BITS{1'b1}}};
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_BLOCKS - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(MAX_BLOCKS);

   // configuration registers
   logic                 fit_mode_ff;
   logic [FIELD_W-1:0]   heap_limit_ff;
   logic [HDR_W-1:0]     header_bytes_ff;

   // control state
   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff;
   logic [ADDR_BITS-1:0] break_ff;
   logic [IW-1:0]        j_ff;
   logic                 rsp_valid_ff;

   // latched item
   logic                 op_ff;
   logic [FIELD_W-1:0]   req_size_ff;
   logic [FIELD_W-1:0]   rel_addr_ff;

   // search results
   logic                 pick_ff;
   logic [IW-1:0]        pick_idx_ff;
   logic [ADDR_BITS-1:0] pick_size_ff, pick_base_ff;
   logic                 found_ff;
   logic [IW-1:0]        m_ff;
   logic [ADDR_BITS-1:0] msize_ff;
   logic                 lastf_ff;
   logic [ADDR_BITS-1:0] lasts_ff;
   logic                 prevf_ff, nextf_ff;
   logic [ADDR_BITS-1:0] prev_size_ff, next_size_ff;

   // merge bookkeeping
   logic [ADDR_BITS-1:0] acc_ff;
   logic [IW-1:0]        s_ff;
   logic [1:0]           del_left_ff;

   // result held for the next reply
   logic [FIELD_W-1:0]   res_addr_ff, rsp_addr_ff;
   logic [STATUS_W-1:0]  res_status_ff, rsp_status_ff;

   // cell row
   cell_ctrl_type        cctrl;
   logic [IW-1:0]        cpos;
   logic [ADDR_BITS-1:0] cwr_base, cwr_size;
   logic [ADDR_BITS-1:0] c_base [MAX_BLOCKS];
   logic [ADDR_BITS-1:0] c_size [MAX_BLOCKS];
   logic                 c_free [MAX_BLOCKS];

   genvar gi;
   generate
      for (gi = 0; gi < MAX_BLOCKS; gi++) begin : g_cell
         // ring: the last cell takes from the head so a full rotation restores order
         localparam int NB = (gi + 1) % MAX_BLOCKS;
         fha_cell #(.ADDR_BITS(ADDR_BITS), .IW(IW), .IDX(gi)) u_cell (
            .clock    (clock),
            .ctrl     (cctrl),
            .pos      (cpos),
            .wr_base  (cwr_base),
            .wr_size  (cwr_size),
            .nbr_base (c_base[NB]),
            .nbr_size (c_size[NB]),
            .nbr_free (c_free[NB]),
            .base     (c_base[gi]),
            .size     (c_size[gi]),
            .free     (c_free[gi])
         );
      end
   endgenerate

   // head cell view and per-step tests
   logic [ADDR_BITS-1:0] head_base, head_size;
   logic                 head_free, in_range, scan_last;
   logic [EW-1:0]        hdr_e, head_size_e, req_size_e, head_addr_e;
   logic                 cand, take_pick, match;

   assign head_base   = c_base[0];
   assign head_size   = c_size[0];
   assign head_free   = c_free[0];
   assign in_range    = CW'(j_ff) < count_ff;
   assign scan_last   = (j_ff == LAST_IDX);
   assign hdr_e       = EW'(header_bytes_ff);
   assign head_size_e = EW'(head_size);
   assign req_size_e  = EW'(req_size_ff);
   assign head_addr_e = EW'(head_base) + hdr_e;
   assign cand        = in_range && head_free && (head_size_e >= req_size_e);
   // first fit keeps the earliest; best fit replaces only on a strictly smaller size
   assign take_pick   = cand && (!pick_ff || (fit_mode_ff && (head_size < pick_size_ff)));
   assign match       = in_range && !found_ff && (head_addr_e == EW'(rel_addr_ff));

   // decision once the ring is parked again
   logic [EW-1:0]        end_e, pick_addr_e, brk_addr_e;
   logic                 no_heap, full, is_alloc;
   logic [STATUS_W-1:0]  dec_status;
   logic [FIELD_W-1:0]   dec_addr;
   logic                 dec_grow, dec_reuse, dec_mark;

   assign is_alloc    = (op_ff == OP_ALLOC);
   assign end_e       = EW'(break_ff) + hdr_e + req_size_e;
   assign no_heap     = (end_e > EW'(heap_limit_ff)) || (end_e > MASK_E);
   assign full        = (count_ff == FULL_CNT);
   assign pick_addr_e = EW'(pick_base_ff) + hdr_e;
   assign brk_addr_e  = EW'(break_ff) + hdr_e;

   always_comb begin
      dec_status = ST_OK;
      dec_addr   = '0;
      dec_grow   = 1'b0;
      dec_reuse  = 1'b0;
      dec_mark   = 1'b0;
      if (is_alloc) begin
         if (req_size_ff == '0) begin
            dec_status = ST_NULL;
         end else if (pick_ff) begin
            dec_reuse = 1'b1;
            dec_addr  = pick_addr_e[FIELD_W-1:0];
         end else if (no_heap) begin
            dec_status = ST_NOHEAP;
         end else if (full) begin
            dec_status = ST_FULL;
         end else begin
            dec_grow = 1'b1;
            dec_addr = brk_addr_e[FIELD_W-1:0];
         end
      end else begin
         if (rel_addr_ff == '0) begin
            dec_status = ST_NULL;
         end else if (!found_ff) begin
            dec_status = ST_UNKNOWN;
         end else begin
            dec_mark = 1'b1;
         end
      end
   end

   // merged size pieces
   logic [ADDR_BITS-1:0] hdr_a, merge_a, merge_b;
   assign hdr_a   = ADDR_BITS'(hdr_e);
   assign merge_a = (prevf_ff ? (prev_size_ff + hdr_a) : '0) + msize_ff;
   assign merge_b = acc_ff + (nextf_ff ? (hdr_a + next_size_ff) : '0);

   logic req_fire, rsp_load;
   assign req_port.ready = (state_ff == S_IDLE);
   assign req_fire       = req_port.valid && req_port.ready;
   assign rsp_load       = (state_ff == S_REPLY) && (!rsp_valid_ff || rsp_port.ready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:     if (req_fire) state_in = S_SCAN;
         S_SCAN:     if (scan_last) state_in = S_DECIDE;
         S_DECIDE:   state_in = dec_mark ? S_MERGE_A : S_REPLY;
         S_MERGE_A:  state_in = S_MERGE_B;
         S_MERGE_B:  state_in = S_MERGE_WR;
         S_MERGE_WR: state_in = (del_left_ff == 2'd0) ? S_REPLY : S_DELETE;
         S_DELETE:   if (del_left_ff == 2'd1) state_in = S_REPLY;
         S_REPLY:    if (rsp_load) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // cell row commands
   always_comb begin
      cctrl    = '0;
      cpos     = '0;
      cwr_base = break_ff;
      cwr_size = ADDR_BITS'(req_size_ff);
      case (state_ff)
         S_SCAN: begin
            cctrl.shift_all = 1'b1;
         end
         S_DECIDE: begin
            if (dec_reuse) begin
               cctrl.wr         = 1'b1;
               cctrl.wr_free_en = 1'b1;
               cpos             = pick_idx_ff;
            end else if (dec_grow) begin
               cctrl.wr         = 1'b1;
               cctrl.wr_base_en = 1'b1;
               cctrl.wr_size_en = 1'b1;
               cctrl.wr_free_en = 1'b1;
               cpos             = count_ff[IW-1:0];
            end else if (dec_mark) begin
               cctrl.wr         = 1'b1;
               cctrl.wr_free_en = 1'b1;
               cctrl.wr_free    = 1'b1;
               cpos             = m_ff;
            end
         end
         S_MERGE_WR: begin
            cctrl.wr         = 1'b1;
            cctrl.wr_size_en = 1'b1;
            cpos             = s_ff;
            cwr_size         = acc_ff;
         end
         S_DELETE: begin
            cctrl.del = 1'b1;
            cpos      = s_ff + IW'(1);
         end
         default: begin
            cctrl = '0;
         end
      endcase
   end

   // configuration writes; the user must write only while idle, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff     <= 1'b0;
         heap_limit_ff   <= 16'hFFFF;
         header_bytes_ff <= 8'd24;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_FIT_MODE:     fit_mode_ff     <= csr_wdata[0];
            CSR_HEAP_LIMIT:   heap_limit_ff   <= csr_wdata;
            CSR_HEADER_BYTES: header_bytes_ff <= csr_wdata[HDR_W-1:0];
            default:          fit_mode_ff     <= fit_mode_ff;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         break_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == S_DECIDE && dec_grow) begin
            count_ff <= count_ff + CW'(1);
            break_ff <= ADDR_BITS'(end_e);
         end else if (state_ff == S_DELETE) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_addr_ff   <= res_addr_ff;
         rsp_status_ff <= res_status_ff;
      end
      case (state_ff)
         S_IDLE: begin
            op_ff       <= req_port.operation;
            req_size_ff <= req_port.request_size;
            rel_addr_ff <= req_port.release_address;
            j_ff        <= '0;
            pick_ff     <= 1'b0;
            found_ff    <= 1'b0;
            nextf_ff    <= 1'b0;
         end
         S_SCAN: begin
            j_ff     <= j_ff + IW'(1);
            lastf_ff <= head_free;
            lasts_ff <= head_size;
            if (is_alloc && take_pick) begin
               pick_ff      <= 1'b1;
               pick_idx_ff  <= j_ff;
               pick_size_ff <= head_size;
               pick_base_ff <= head_base;
            end
            if (match) begin
               found_ff     <= 1'b1;
               m_ff         <= j_ff;
               msize_ff     <= head_size;
               prevf_ff     <= (j_ff != '0) && lastf_ff;
               prev_size_ff <= lasts_ff;
            end
            // entry just after the freed one
            if (found_ff && in_range && (j_ff == m_ff + IW'(1))) begin
               nextf_ff     <= head_free;
               next_size_ff <= head_size;
            end
         end
         S_DECIDE: begin
            res_status_ff <= dec_status;
            res_addr_ff   <= dec_addr;
         end
         S_MERGE_A: begin
            acc_ff      <= merge_a;
            s_ff        <= prevf_ff ? (m_ff - IW'(1)) : m_ff;
            del_left_ff <= {1'b0, prevf_ff} + {1'b0, nextf_ff};
         end
         S_MERGE_B: begin
            acc_ff <= merge_b;
         end
         S_DELETE: begin
            del_left_ff <= del_left_ff - 2'd1;
         end
         default: begin
            j_ff <= j_ff;
         end
      endcase
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.data_address = rsp_addr_ff;
   assign rsp_port.status       = rsp_status_ff;

`ifndef SYNTH
   // table never holds more entries than cells
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT) else $error("block count above table size");

   // an accepted item always starts a ring rotation
   a_fire_scan: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_SCAN) else $error("accepted item did not start scan");

   // count moves by at most one entry per cycle
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         (count_ff == $past(count_ff) + CW'(1) || count_ff == $past(count_ff) - CW'(1)))
      else $error("block count jumped");

   // the heap break only grows, and only on an append
   a_break_grow: assert property (@(posedge clock) disable iff (reset)
      (break_ff != $past(break_ff)) |-> (count_ff == $past(count_ff) + CW'(1)))
      else $error("heap break moved without an append");
`endif
endmodule

[dv/tb_fit_heap_allocator_unit.sv]
// self-checking testbench of the fit heap allocator unit
`timescale 1ns / 100ps

module tb_fit_heap_allocator_unit;
   import fha_pkg::*;

   localparam int NBLK        = MAX_BLOCKS_DEF;
   localparam int RAND_ITEMS  = 1900;
   localparam int PHASES      = 8;
   localparam int DRAIN_WAIT  = NBLK + 8 + 20;  // worst item latency with margin
   localparam int STALL_LIMIT = 4000;           // cycles without any item moving

   logic clock;
   logic reset;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [FIELD_W-1:0]   csr_wdata;

   fha_req_if req_if ();
   fha_rsp_if rsp_if ();

   fit_heap_allocator_unit u_top (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_port     (req_if),
      .rsp_port     (rsp_if)
   );

   // one expected response
   typedef struct {
      logic [FIELD_W-1:0]  data_address;
      logic [STATUS_W-1:0] status;
   } grant_type;

   // directed stimulus row; pinned rows carry a typed-in response
   typedef struct {
      logic                op;
      logic [FIELD_W-1:0]  size;
      logic [FIELD_W-1:0]  addr;
      bit                  pinned;
      logic [FIELD_W-1:0]  exp_addr;
      logic [STATUS_W-1:0] exp_status;
   } row_type;

   // shadow copy of the allocator state and its registers
   logic [FIELD_W-1:0] shadow_base [NBLK];
   logic [FIELD_W-1:0] shadow_size [NBLK];
   bit                 shadow_free [NBLK];
   int                 shadow_count;
   int unsigned        shadow_break;
   bit                 cfg_best_fit;
   int unsigned        cfg_limit;
   int unsigned        cfg_header;

   grant_type          pending_grants[$];
   logic [FIELD_W-1:0] handed_out[$];     // most recent data addresses granted, up to 64
   int                 errors;
   int                 idle_cycles;
   int                 n_alloc, n_free, n_status[5];
   bit                 stim_done;
   int                 rsp_stall;

   // merge every run of adjacent free entries into its first entry
   function automatic void coalesce_free_runs();
      int i;
      i = 0;
      while (i + 1 < shadow_count) begin
         if (shadow_free[i] && shadow_free[i+1]) begin
            shadow_size[i] = FIELD_W'(shadow_size[i] + cfg_header + shadow_size[i+1]);
            for (int k = i + 1; k + 1 < shadow_count; k++) begin
               shadow_base[k] = shadow_base[k+1];
               shadow_size[k] = shadow_size[k+1];
               shadow_free[k] = shadow_free[k+1];
            end
            shadow_count--;
         end else begin
            i++;
         end
      end
   endfunction

   // apply one item to the shadow heap and return the response it causes
   function automatic grant_type heap_step(logic op, logic [FIELD_W-1:0] size,
                                           logic [FIELD_W-1:0] addr);
      grant_type   g;
      int          pick;
      int unsigned brk_end;
      g.data_address = '0;
      g.status       = ST_OK;
      pick           = -1;
      if (op == OP_ALLOC) begin
         if (size == 0) begin
            g.status = ST_NULL;
            return g;
         end
         for (int i = 0; i < shadow_count; i++) begin
            if (shadow_free[i] && shadow_size[i] >= size) begin
               if (!cfg_best_fit) begin
                  pick = i;
                  break;
               end
               if (pick < 0 || shadow_size[i] < shadow_size[pick]) pick = i;
            end
         end
         if (pick >= 0) begin
            shadow_free[pick] = 0;
            g.data_address = FIELD_W'(shadow_base[pick] + cfg_header);
            return g;
         end
         brk_end = shadow_break + cfg_header + size;
         if (brk_end > cfg_limit || brk_end > 65535) begin
            g.status = ST_NOHEAP;
            return g;
         end
         if (shadow_count >= NBLK) begin
            g.status = ST_FULL;
            return g;
         end
         shadow_base[shadow_count] = FIELD_W'(shadow_break);
         shadow_size[shadow_count] = size;
         shadow_free[shadow_count] = 0;
         shadow_count++;
         g.data_address = FIELD_W'(shadow_break + cfg_header);
         shadow_break   = brk_end;
      end else begin
         if (addr == 0) begin
            g.status = ST_NULL;
            return g;
         end
         // compare at full width: base plus header may pass the address range
         for (int i = 0; i < shadow_count; i++) begin
            if (int'(shadow_base[i]) + int'(cfg_header) == int'(addr)) begin
               shadow_free[i] = 1;
               coalesce_free_runs();
               return g;
            end
         end
         g.status = ST_UNKNOWN;
      end
      return g;
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // register write, only called while the block is idle
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int unsigned value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= FIELD_W'(value);
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_FIT_MODE:     cfg_best_fit = value[0];
         CSR_HEAP_LIMIT:   cfg_limit    = value & 16'hFFFF;
         CSR_HEADER_BYTES: cfg_header   = value & 8'hFF;
         default: ;
      endcase
   endtask

   // hand one item over; valid stays high across back-to-back items
   task automatic send_item(logic op, logic [FIELD_W-1:0] size, logic [FIELD_W-1:0] addr,
                            bit pinned, grant_type pinned_grant);
      int        gap;
      grant_type g;
      gap = $urandom_range(0, 18);
      if ($urandom_range(0, 3) == 0) gap = 0;   // keep runs of back-to-back items
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid           <= 1'b1;
      req_if.operation       <= op;
      req_if.request_size    <= size;
      req_if.release_address <= addr;
      do @(posedge clock); while (!req_if.ready);
      g = heap_step(op, size, addr);
      if (pinned) g = pinned_grant;
      pending_grants.push_back(g);
      if (op == OP_ALLOC) n_alloc++; else n_free++;
      if (op == OP_ALLOC && g.status == ST_OK) begin
         handed_out.push_back(g.data_address);
         if (handed_out.size() > 64) void'(handed_out.pop_front());
      end
   endtask

   // wait for every response, then for the block to settle
   task automatic drain();
      req_if.valid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // main stimulus
   initial begin
      row_type   rows[$];
      row_type   r;
      grant_type pg;
      logic      op;
      logic [FIELD_W-1:0] size, addr;
      int        pct;
      int unsigned phase_cfg[PHASES][3] = '{
         '{0, 65535, 24}, '{1, 65535, 24}, '{1, 65535, 1}, '{0, 6000, 255},
         '{1, 0, 40},     '{0, 65535, 255}, '{1, 30000, 7}, '{0, 65535, 1}};

      errors = 0; n_alloc = 0; n_free = 0; stim_done = 0;
      foreach (n_status[i]) n_status[i] = 0;
      shadow_count = 0; shadow_break = 0;
      cfg_best_fit = 0; cfg_limit = 65535; cfg_header = 24;

      reset                  <= 1'b1;
      csr_write_en           <= 1'b0;
      csr_index              <= CSR_FIT_MODE;
      csr_wdata              <= '0;
      req_if.valid           <= 1'b0;
      req_if.operation       <= OP_ALLOC;
      req_if.request_size    <= '0;
      req_if.release_address <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, header 24 and first fit from reset
      rows = '{
         '{OP_ALLOC, 16'd0,     16'd0,     1, 16'd0,   ST_NULL},
         '{OP_ALLOC, 16'd100,   16'd0,     1, 16'd24,  ST_OK},
         '{OP_ALLOC, 16'hFFFF,  16'd0,     1, 16'd0,   ST_NOHEAP},
         '{OP_FREE,  16'd0,     16'd0,     1, 16'd0,   ST_NULL},
         '{OP_FREE,  16'd0,     16'd5,     1, 16'd0,   ST_UNKNOWN},
         '{OP_FREE,  16'hFFFF,  16'hFFFF,  1, 16'd0,   ST_UNKNOWN},
         '{OP_FREE,  16'd0,     16'd24,    1, 16'd0,   ST_OK},
         '{OP_ALLOC, 16'd50,    16'd0,     1, 16'd24,  ST_OK},
         '{OP_FREE,  16'd0,     16'd24,    1, 16'd0,   ST_OK},
         '{OP_FREE,  16'd0,     16'd24,    1, 16'd0,   ST_OK},   // double free
         '{OP_ALLOC, 16'd200,   16'd0,     1, 16'd148, ST_OK},
         '{OP_ALLOC, 16'd1,     16'd0,     0, 16'd0,   ST_OK},
         '{OP_ALLOC, 16'd30,    16'd0,     0, 16'd0,   ST_OK},
         '{OP_ALLOC, 16'd300,   16'd0,     0, 16'd0,   ST_OK},
         '{OP_FREE,  16'd0,     16'd148,   0, 16'd0,   ST_OK},
         '{OP_FREE,  16'd0,     16'd373,   0, 16'd0,   ST_OK},   // matches no entry: status unknown
         '{OP_ALLOC, 16'd20,    16'd0,     0, 16'd0,   ST_OK},
         '{OP_ALLOC, 16'd64000, 16'd0,     0, 16'd0,   ST_OK},
         '{OP_ALLOC, 16'd2000,  16'd0,     0, 16'd0,   ST_OK}    // past the limit
      };
      foreach (rows[i]) begin
         r = rows[i];
         pg.data_address = r.exp_addr;
         pg.status       = r.exp_status;
         send_item(r.op, r.size, r.addr, r.pinned, pg);
      end
      // sender holds off until the block has answered everything
      drain();

      // random phases, each under its own register setting
      for (int ph = 0; ph < PHASES; ph++) begin
         write_csr(CSR_FIT_MODE,     phase_cfg[ph][0]);
         write_csr(CSR_HEAP_LIMIT,   phase_cfg[ph][1]);
         write_csr(CSR_HEADER_BYTES, phase_cfg[ph][2]);
         for (int n = 0; n < RAND_ITEMS / PHASES; n++) begin
            pct  = $urandom_range(0, 99);
            op   = (pct < 50) ? OP_ALLOC : OP_FREE;
            size = FIELD_W'($urandom);
            addr = FIELD_W'($urandom);
            if (op == OP_ALLOC) begin
               pct = $urandom_range(0, 99);
               if (pct < 65)      size = FIELD_W'($urandom_range(1, 400));
               else if (pct < 85) size = FIELD_W'($urandom_range(1, 60));
               else if (pct < 95) size = FIELD_W'($urandom);
               else               size = '0;
            end else begin
               pct = $urandom_range(0, 99);
               if (pct < 80 && handed_out.size() > 0)
                  addr = handed_out[$urandom_range(0, handed_out.size() - 1)];
               else if (pct < 88)
                  addr = '0;
            end
            send_item(op, size, addr, 0, pg);
         end
         drain();
      end
      stim_done = 1;
   end

   // response side: random stalls, checks in acceptance order
   always @(posedge clock) begin
      grant_type g;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall    = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_grants.size() == 0) begin
               $error("response with nothing expected: addr %0d status %0d",
                      rsp_if.data_address, rsp_if.status);
               errors++;
            end else begin
               g = pending_grants.pop_front();
               if (rsp_if.data_address !== g.data_address) begin
                  $error("data_address: expected %0d, got %0d",
                         g.data_address, rsp_if.data_address);
                  errors++;
               end
               if (rsp_if.status !== g.status) begin
                  $error("status: expected %0d, got %0d", g.status, rsp_if.status);
                  errors++;
               end
               if (g.status <= ST_UNKNOWN) n_status[g.status]++;
            end
            rsp_stall = $urandom_range(0, 18);
            if ($urandom_range(0, 3) == 0) rsp_stall = 0;
         end
         if (rsp_stall > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // watchdog and end of run
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (!reset && idle_cycles >= STALL_LIMIT && !stim_done) begin
         $display("timeout with %0d responses outstanding", pending_grants.size());
         $display("[fit_heap_allocator_unit] ERROR");
         $finish;
      end else if (stim_done) begin
         $display("covered %0d allocates and %0d frees over %0d register settings",
                  n_alloc, n_free, PHASES + 1);
         $display("statuses ok %0d, null %0d, out of heap %0d, full %0d, unknown %0d",
                  n_status[0], n_status[1], n_status[2], n_status[3], n_status[4]);
         if (errors == 0 && pending_grants.size() == 0)
            $display("[fit_heap_allocator_unit] OK");
         else
            $display("[fit_heap_allocator_unit] ERROR");
         $finish;
      end
   end

endmodule
